// ===== rtl/cde_pkg.sv =====
// Package for the circular deque engine: operation and status codes,
// controller states and the controller-to-datapath command struct.
// No dependencies; every other file of the block refers to it.
`default_nettype none

package cde_pkg;

    localparam int KIND_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    localparam logic [VALUE_W-1:0] NEG_ONE = {VALUE_W{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        K_PUSH_FRONT = 2'd0,
        K_PUSH_BACK  = 2'd1,
        K_POP_FRONT  = 2'd2,
        K_POP_BACK   = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic accept;
        logic load_out;
    } t_dp_cmd;

endpackage

`default_nettype wire

// ===== rtl/cde_if.sv =====
// Valid/ready channel interfaces of the circular deque engine: requests in,
// responses out. Depends on cde_pkg for field widths.
`default_nettype none

interface cde_req_if;
    logic                                valid;
    logic                                ready;
    logic [cde_pkg::KIND_W-1:0]          kind;
    logic signed [cde_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface cde_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [cde_pkg::VALUE_W-1:0]  value_out;
    logic [cde_pkg::STATUS_W-1:0]        status;
    logic                                is_empty;
    logic                                is_full;

    modport source (output valid, output value_out, output status,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input value_out, input status,
                    input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

// ===== rtl/cde_ctrl.sv =====
// Controller of the circular deque engine: sequences accept and execute,
// and owns the response valid flag. Depends on cde_pkg.
`default_nettype none

module cde_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_out_ready,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output cde_pkg::t_dp_cmd      o_cmd
);

    cde_pkg::t_state r_state;
    cde_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            can_load;

    // The output register can take a new result when empty or being drained.
    assign can_load = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            cde_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = cde_pkg::S_EXEC;
                end
            end
            cde_pkg::S_EXEC: begin
                if (can_load) begin
                    n_state = cde_pkg::S_IDLE;
                end
            end
            default: n_state = cde_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.accept   = 1'b0;
        o_cmd.load_out = 1'b0;
        case (r_state)
            cde_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            cde_pkg::S_EXEC: begin
                o_cmd.load_out = can_load;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cde_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cde_dp.sv =====
// Datapath of the circular deque engine: ring pointers, slot memory with
// registered read, and the response register. Depends on cde_pkg.
`default_nettype none

module cde_dp #(
    parameter int DEPTH = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  cde_pkg::t_dp_cmd                    i_cmd,
    input  wire logic [cde_pkg::KIND_W-1:0]     i_kind,
    input  wire logic [cde_pkg::VALUE_W-1:0]    i_value,
    output logic [cde_pkg::VALUE_W-1:0]         o_value_out,
    output logic [cde_pkg::STATUS_W-1:0]        o_status,
    output logic                                o_is_empty,
    output logic                                o_is_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [cde_pkg::VALUE_W-1:0] r_slots [DEPTH];
    logic [cde_pkg::VALUE_W-1:0] r_rd_data;

    logic [AW-1:0]    r_front;
    logic [AW-1:0]    r_back;
    logic [AW-1:0]    n_front;
    logic [AW-1:0]    n_back;
    logic [AW-1:0]    front_next;
    logic [AW-1:0]    front_prev;
    logic [AW-1:0]    back_next;
    logic [AW-1:0]    back_prev;
    logic [AW-1:0]    n_back_next;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic             is_empty_now;
    logic             is_full_now;
    cde_pkg::t_kind   kind;
    cde_pkg::t_status n_status;
    logic             n_pop_ok;

    // Result fields of the item in flight, held until the read data returns.
    cde_pkg::t_status r_status;
    logic             r_pop_ok;
    logic             r_empty;
    logic             r_full;

    assign kind         = cde_pkg::t_kind'(i_kind);
    assign front_next   = (r_front == LAST) ? '0 : r_front + 1'b1;
    assign front_prev   = (r_front == '0) ? LAST : r_front - 1'b1;
    assign back_next    = (r_back == LAST) ? '0 : r_back + 1'b1;
    assign back_prev    = (r_back == '0) ? LAST : r_back - 1'b1;
    assign is_empty_now = (r_front == r_back);
    assign is_full_now  = (back_next == r_front);

    always_comb begin
        n_front  = r_front;
        n_back   = r_back;
        n_status = cde_pkg::ST_DONE;
        n_pop_ok = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = r_front;
        rd_addr  = r_back;
        case (kind)
            cde_pkg::K_PUSH_FRONT: begin
                wr_addr = r_front;
                if (is_full_now) begin
                    n_status = cde_pkg::ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_front = front_prev;
                end
            end
            cde_pkg::K_PUSH_BACK: begin
                wr_addr = back_next;
                if (is_full_now) begin
                    n_status = cde_pkg::ST_FULL;
                end else begin
                    wr_en  = 1'b1;
                    n_back = back_next;
                end
            end
            cde_pkg::K_POP_FRONT: begin
                rd_addr = front_next;
                if (is_empty_now) begin
                    n_status = cde_pkg::ST_EMPTY;
                end else begin
                    n_pop_ok = 1'b1;
                    n_front  = front_next;
                end
            end
            cde_pkg::K_POP_BACK: begin
                rd_addr = r_back;
                if (is_empty_now) begin
                    n_status = cde_pkg::ST_EMPTY;
                end else begin
                    n_pop_ok = 1'b1;
                    n_back   = back_prev;
                end
            end
            default: begin
                n_status = cde_pkg::ST_DONE;
            end
        endcase
    end

    assign n_back_next = (n_back == LAST) ? '0 : n_back + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && wr_en) begin
            r_slots[wr_addr] <= i_value;
        end
        if (i_cmd.accept) begin
            r_rd_data <= r_slots[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= LAST;
            r_back  <= LAST;
        end else if (i_cmd.accept) begin
            r_front <= n_front;
            r_back  <= n_back;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_status <= n_status;
            r_pop_ok <= n_pop_ok;
            r_empty  <= (n_front == n_back);
            r_full   <= (n_back_next == n_front);
        end
        if (i_cmd.load_out) begin
            o_value_out <= r_pop_ok ? r_rd_data : cde_pkg::NEG_ONE;
            o_status    <= r_status;
            o_is_empty  <= r_empty;
            o_is_full   <= r_full;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/circular_deque_engine_core.sv =====
// Top level of the circular deque engine: joins controller and datapath
// to the request and response channels. Depends on cde_pkg, cde_if,
// cde_ctrl and cde_dp.
//
//  Channel | Direction | Payload
//  --------+-----------+--------------------------------------------
//  i_req   | in        | kind, value
//  o_rsp   | out       | value_out, status, is_empty, is_full
//
// Each operation has an accept cycle, which updates the pointers, writes a
// pushed value and starts the slot read, and then an execute cycle, which
// loads the response register from the registered read data. No request is
// taken while an execute cycle is pending. A waiting response does not
// block the next request; the execute cycle stalls only while the response
// register still holds an untaken transaction. Synchronous reset empties
// the deque (both pointers at DEPTH-1); slot contents are not cleared.
`default_nettype none

module circular_deque_engine_core #(
    parameter int DEPTH = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cde_req_if.sink    i_req,
    cde_rsp_if.source  o_rsp
);

    cde_pkg::t_dp_cmd            cmd;
    logic [cde_pkg::VALUE_W-1:0] value_out;

    cde_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (cmd)
    );

    cde_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_kind      (i_req.kind),
        .i_value     (i_req.value),
        .o_value_out (value_out),
        .o_status    (o_rsp.status),
        .o_is_empty  (o_rsp.is_empty),
        .o_is_full   (o_rsp.is_full)
    );

    assign o_rsp.value_out = value_out;

    // A request is never accepted directly after another one.
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request accepted in the cycle after an accept");

    // With at least two slots the deque is never empty and full at once.
    a_empty_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.is_empty && o_rsp.is_full))
        else $error("response reports empty and full together");

    // A refused push leaves the deque full.
    a_full_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.status == cde_pkg::ST_FULL) |-> o_rsp.is_full)
        else $error("full refusal while deque not full");

    // A refused pop leaves the deque empty and returns all ones.
    a_empty_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.status == cde_pkg::ST_EMPTY)
            |-> o_rsp.is_empty && (o_rsp.value_out == cde_pkg::NEG_ONE))
        else $error("empty refusal with wrong flags or value");

endmodule

`default_nettype wire
